[src/hex_digest_table_lookup_defines.svh]
// Assertion macros for the hex digest table lookup block.
`ifndef HEX_DIGEST_TABLE_LOOKUP_DEFINES_SVH
`define HEX_DIGEST_TABLE_LOOKUP_DEFINES_SVH

`ifndef SYNTH
`define HDTL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hdtl: assertion failed");
`define HDTL_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("hdtl: forbidden condition seen");
`else
`define HDTL_ASSERT(lbl, prop)
`define HDTL_ASSERT_NEVER(lbl, expr)
`endif

`endif

[src/hdtl_pkg.sv]
// Shared types, constants and helpers of the hex digest table lookup block.
`default_nettype none

package hdtl_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 1024;
  localparam int unsigned NUM_CELLS         = 4;
  localparam int unsigned CELL_SH           = 2;   // log2 of NUM_CELLS
  localparam int unsigned DIGEST_W          = 128;
  localparam int unsigned ENTRY_COUNT_W     = 11;
  localparam logic [4:0]  DIGEST_BYTES      = 5'd16;

  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_LO_A  = 8'h61;
  localparam logic [7:0] CHR_LO_F  = 8'h66;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_UP_F  = 8'h46;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  // scan token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } hdtl_tok_t;

  typedef struct packed {
    logic take;
    logic clear;
  } parse_ctl_t;

  typedef struct packed {
    logic                ok;
    logic [DIGEST_W-1:0] digest;
  } parse_res_t;

  function automatic int unsigned bank_depth(input int unsigned entries);
    return (entries + NUM_CELLS - 1) / NUM_CELLS;
  endfunction

  function automatic int unsigned row_w(input int unsigned entries);
    int unsigned d;
    d = bank_depth(entries);
    return (d > 1) ? $clog2(d) : 1;
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= CHR_0 && c <= CHR_9) begin
      v = {1'b0, 4'(c - CHR_0)};
    end else if (c >= CHR_LO_A && c <= CHR_LO_F) begin
      v = {1'b0, 4'(c - CHR_LO_A + 8'd10)};
    end else if (c >= CHR_UP_A && c <= CHR_UP_F) begin
      v = {1'b0, 4'(c - CHR_UP_A + 8'd10)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[src/hdtl_if.sv]
// Request and result channel interfaces.
`default_nettype none

interface hdtl_in_if;
  logic                valid;
  logic                ready;
  hdtl_pkg::func_e     func;
  logic [7:0]          char_byte;
  logic                last_char;
  logic [63:0]         query_hi;
  logic [63:0]         query_lo;

  modport source (output valid, func, char_byte, last_char, query_hi, query_lo,
                  input ready);
  modport sink   (input valid, func, char_byte, last_char, query_hi, query_lo,
                  output ready);
endinterface

interface hdtl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  found;
  logic                                  parse_ok;
  logic                                  table_full;
  logic [hdtl_pkg::ENTRY_COUNT_W-1:0]    entry_count;

  modport source (output valid, found, parse_ok, table_full, entry_count,
                  input ready);
  modport sink   (input valid, found, parse_ok, table_full, entry_count,
                  output ready);
endinterface

`default_nettype wire

[src/hex_digest_table_lookup.sv]
// Top level of the hex digest table lookup block.
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    func, char_byte, last_char, query_hi, query_lo
//   out_o     out  valid/ready    found, parse_ok, table_full, entry_count
//
// Clear and record characters need no scan; a record end writes one
// table bank and returns its result in the output register the next cycle.
// A query scans ceil(count / 4) table rows through a chain of four cells, two
// register stages per cell. The table needs no clearing pass; only entries
// below the count are compared. A request is taken only while no query runs
// and the output register is free or being emptied in the same cycle.
`default_nettype none

module hex_digest_table_lookup #(
  parameter int unsigned TABLE_ENTRIES = hdtl_pkg::DEF_TABLE_ENTRIES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  hdtl_in_if.sink          in_i,
  hdtl_out_if.source       out_o
);
  import hdtl_pkg::*;

`include "hex_digest_table_lookup_defines.svh"

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RW    = row_w(TABLE_ENTRIES);

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [RW-1:0]          row_q, row_d;
  logic [RW-1:0]          last_row;
  logic                   found_q, found_d;
  logic [63:0]            qhi_q, qlo_q;

  logic                   out_valid_q, out_valid_d;
  logic                   out_found_q, out_ok_q, out_full_q;
  logic [ENTRY_COUNT_W-1:0] out_count_q;

  logic                   res_load, res_found, res_ok, res_full;
  logic [ENTRY_COUNT_W-1:0] res_count;

  logic                   accept, out_free, in_ready;
  logic                   rec_end, is_full, wr_en;
  parse_ctl_t             pctl;
  parse_res_t             pres;
  hdtl_tok_t              head_tok;
  hdtl_tok_t              tok [NUM_CELLS+1];
  logic [RW-1:0]          row [NUM_CELLS+1];
  logic [NUM_CELLS-1:0]   cell_we;

  assign out_free  = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_ready;
  assign rec_end   = accept && (in_i.func == FUNC_CHAR) && in_i.last_char;
  assign is_full   = count_q >= CNT_W'(TABLE_ENTRIES);
  assign wr_en     = rec_end && !is_full;
  assign last_row  = RW'((count_q - CNT_W'(1)) >> CELL_SH);

  assign pctl.take  = accept && (in_i.func == FUNC_CHAR);
  assign pctl.clear = accept && ((in_i.func == FUNC_CLEAR) || rec_end);

  hdtl_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pctl),
    .char_i (in_i.char_byte),
    .res_o  (pres)
  );

  assign tok[0] = head_tok;
  assign row[0] = row_q;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    assign cell_we[c] = wr_en && (CELL_SH'(count_q) == CELL_SH'(c));

    hdtl_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .CELL_IDX      (c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[c]),
      .row_i   (row[c]),
      .query_i ({qhi_q, qlo_q}),
      .count_i (count_q),
      .we_i    (cell_we[c]),
      .waddr_i (RW'(count_q >> CELL_SH)),
      .wdata_i (pres.digest),
      .tok_o   (tok[c+1]),
      .row_o   (row[c+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.func == FUNC_QUERY) && (count_q != '0)) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (row_q == last_row) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tok[NUM_CELLS].valid && tok[NUM_CELLS].last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_ready  = 1'b0;
    count_d   = count_q;
    row_d     = row_q;
    found_d   = found_q;
    head_tok  = '0;
    res_load  = 1'b0;
    res_found = 1'b0;
    res_ok    = 1'b0;
    res_full  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          case (in_i.func)
            FUNC_CLEAR: begin
              count_d  = '0;
              res_load = 1'b1;
            end
            FUNC_CHAR: begin
              if (in_i.last_char) begin
                res_load = 1'b1;
                res_ok   = pres.ok;
                res_full = is_full;
                if (!is_full) begin
                  count_d = count_q + CNT_W'(1);
                end
              end
            end
            FUNC_QUERY: begin
              row_d   = '0;
              found_d = 1'b0;
              if (count_q == '0) begin
                res_load = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        head_tok.valid = 1'b1;
        head_tok.last  = (row_q == last_row);
        row_d          = row_q + RW'(1);
        found_d        = found_q | (tok[NUM_CELLS].valid & tok[NUM_CELLS].hit);
      end
      ST_DRAIN: begin
        found_d = found_q | (tok[NUM_CELLS].valid & tok[NUM_CELLS].hit);
      end
      ST_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_found = found_q;
        end
      end
      default: ;
    endcase
  end

  assign res_count   = ENTRY_COUNT_W'(count_d);
  assign out_valid_d = res_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      row_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      row_q       <= row_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_i.func == FUNC_QUERY)) begin
      qhi_q <= in_i.query_hi;
      qlo_q <= in_i.query_lo;
    end
    if (res_load) begin
      out_found_q <= res_found;
      out_ok_q    <= res_ok;
      out_full_q  <= res_full;
      out_count_q <= res_count;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.parse_ok    = out_ok_q;
  assign out_o.table_full  = out_full_q;
  assign out_o.entry_count = out_count_q;

  `HDTL_ASSERT(a_count_bound, count_q <= CNT_W'(TABLE_ENTRIES))
  `HDTL_ASSERT(a_count_held_in_scan, state_q != ST_IDLE |=> $stable(count_q))
  `HDTL_ASSERT(a_tail_last_row, (tok[NUM_CELLS].valid && tok[NUM_CELLS].last) |-> (row[NUM_CELLS] == last_row))
  `HDTL_ASSERT(a_one_bank_write, $onehot0(cell_we))
  `HDTL_ASSERT_NEVER(a_tail_outside_scan, tok[NUM_CELLS].valid && (state_q == ST_IDLE || state_q == ST_DONE))

endmodule

`default_nettype wire

[src/hdtl_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module hdtl_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/hdtl_parser.sv]
// Hex text record assembler: pairs digits into bytes and judges the record.
`default_nettype none

module hdtl_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hdtl_pkg::parse_ctl_t    ctl_i,
  input  logic [7:0]              char_i,
  output hdtl_pkg::parse_res_t    res_o
);
  import hdtl_pkg::*;

  logic [63:0] hi_q, hi_d;
  logic [63:0] lo_q, lo_d;
  logic [4:0]  bytes_q, bytes_d;
  logic [3:0]  pend_q, pend_d;
  logic        wait_q, wait_d;
  logic        ovf_q, ovf_d;
  logic [4:0]  hv;
  logic        ok;

  assign hv = hex_value(char_i);

  // state after the current character, before any clear
  always_comb begin
    hi_d    = hi_q;
    lo_d    = lo_q;
    bytes_d = bytes_q;
    pend_d  = pend_q;
    wait_d  = wait_q;
    ovf_d   = ovf_q;
    if (ctl_i.take && !hv[4] && !ovf_q) begin
      if (!wait_q) begin
        pend_d = hv[3:0];
        wait_d = 1'b1;
      end else begin
        wait_d = 1'b0;
        if (bytes_q >= DIGEST_BYTES) begin
          ovf_d = 1'b1;
        end else begin
          hi_d    = {hi_q[55:0], lo_q[63:56]};
          lo_d    = {lo_q[55:0], pend_q, hv[3:0]};
          pend_d  = 4'd0;
          bytes_d = bytes_q + 5'd1;
        end
      end
    end
  end

  assign ok            = !ovf_d && (bytes_d == DIGEST_BYTES);
  assign res_o.ok      = ok;
  assign res_o.digest  = ok ? {hi_d, lo_d} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q    <= '0;
      lo_q    <= '0;
      bytes_q <= '0;
      pend_q  <= '0;
      wait_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (ctl_i.clear) begin
      hi_q    <= '0;
      lo_q    <= '0;
      bytes_q <= '0;
      pend_q  <= '0;
      wait_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      bytes_q <= bytes_d;
      pend_q  <= pend_d;
      wait_q  <= wait_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

[src/hdtl_cell.sv]
// One scan cell: a bank of the digest table plus a compare stage.
`default_nettype none

module hdtl_cell #(
  parameter int unsigned TABLE_ENTRIES = hdtl_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned CELL_IDX      = 0
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  hdtl_pkg::hdtl_tok_t                         tok_i,
  input  logic [hdtl_pkg::row_w(TABLE_ENTRIES)-1:0]   row_i,
  input  logic [hdtl_pkg::DIGEST_W-1:0]               query_i,
  input  logic [$clog2(TABLE_ENTRIES + 1)-1:0]        count_i,
  input  logic                                        we_i,
  input  logic [hdtl_pkg::row_w(TABLE_ENTRIES)-1:0]   waddr_i,
  input  logic [hdtl_pkg::DIGEST_W-1:0]               wdata_i,
  output hdtl_pkg::hdtl_tok_t                         tok_o,
  output logic [hdtl_pkg::row_w(TABLE_ENTRIES)-1:0]   row_o
);
  import hdtl_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RW    = row_w(TABLE_ENTRIES);
  localparam int unsigned IDX_W = RW + CELL_SH;
  localparam int unsigned CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  hdtl_tok_t          a_tok_q, out_tok_q;
  logic [RW-1:0]      a_row_q, out_row_q;
  logic [DIGEST_W-1:0] rdata;
  logic [IDX_W-1:0]   idx;
  logic               entry_live;
  logic               match;

  hdtl_ram #(
    .WIDTH (DIGEST_W),
    .DEPTH (bank_depth(TABLE_ENTRIES))
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (row_i),
    .rdata_o (rdata)
  );

  // global entry index of the row being compared in this cell
  assign idx        = {a_row_q, CELL_SH'(CELL_IDX)};
  assign entry_live = CMP_W'(idx) < CMP_W'(count_i);
  assign match      = a_tok_q.valid && entry_live && (rdata == query_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tok_q   <= '0;
      out_tok_q <= '0;
    end else begin
      a_tok_q         <= tok_i;
      out_tok_q.valid <= a_tok_q.valid;
      out_tok_q.last  <= a_tok_q.last;
      out_tok_q.hit   <= a_tok_q.hit | match;
    end
  end

  always_ff @(posedge clk_i) begin
    a_row_q   <= row_i;
    out_row_q <= a_row_q;
  end

  assign tok_o = out_tok_q;
  assign row_o = out_row_q;

endmodule

`default_nettype wire
